[rtl/ssetb_pkg.sv]
`default_nettype none

package ssetb_pkg;

    // Request kinds carried on s_tuser
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 7;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture the request fields
        logic compare;  // run the per-entry comparators
        logic commit;   // update the table and load the result register
    } dp_cmd_t;

endpackage

`default_nettype wire

[rtl/ssetb_ctrl.sv]
`default_nettype none

module ssetb_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output ssetb_pkg::dp_cmd_t    cmd
);
    import ssetb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       commit;
    logic       load;

    // Commit only when the result register is free or being drained
    assign commit   = (state_reg == ST_UPD) && (!out_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE) || commit;
    assign load     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    assign cmd.load    = load;
    assign cmd.compare = (state_reg == ST_CMP);
    assign cmd.commit  = commit;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (load) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (commit) begin
                    state_next = load ? ST_CMP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ssetb_dp.sv]
`default_nettype none

module ssetb_dp #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire ssetb_pkg::dp_cmd_t                  cmd,
    input  wire logic [1:0]                          req_mode,
    input  wire logic signed [ssetb_pkg::VALUE_W-1:0] req_value,
    output logic                                     res_success,
    output logic                                     res_full,
    output logic [ssetb_pkg::COUNT_W-1:0]            res_count
);
    import ssetb_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [1:0]                mode_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] entry_reg [CAPACITY];
    logic [CAPACITY-1:0]       lt_reg, lt_next;
    logic [CAPACITY-1:0]       eq_vec;
    logic                      hit_reg;
    logic [CW-1:0]             count_reg, count_next;
    logic                      add_ok, rem_ok, ok;
    logic                      success_reg, full_reg;
    logic [COUNT_W-1:0]        count_out_reg;

    // Per-entry comparators; the table is sorted, so lt is a thermometer
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cmp
            logic valid;
            assign valid       = (CW'(gi) < count_reg);
            assign lt_next[gi] = valid && (entry_reg[gi] < value_reg);
            assign eq_vec[gi]  = valid && (entry_reg[gi] == value_reg);
        end
    endgenerate

    assign add_ok = (mode_reg == MODE_ADD) && !hit_reg && (count_reg < CW'(CAPACITY));
    assign rem_ok = (mode_reg == MODE_REMOVE) && hit_reg;
    assign ok     = add_ok || rem_ok || ((mode_reg == MODE_QUERY) && hit_reg);

    always_comb begin
        priority if (add_ok) begin
            count_next = count_reg + CW'(1);
        end else if (rem_ok) begin
            count_next = count_reg - CW'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= req_mode;
            value_reg <= req_value;
        end
        if (cmd.compare) begin
            lt_reg  <= lt_next;
            hit_reg <= |eq_vec;
        end
        if (cmd.commit) begin
            success_reg   <= ok;
            full_reg      <= (count_next == CW'(CAPACITY));
            count_out_reg <= COUNT_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= count_next;
        end
    end

    // Shifting table: open a slot at the insert point or close the removed one
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_entry
            logic at_pos;
            logic take_up;
            if (gi == 0) begin : g_first
                assign at_pos = !lt_reg[gi];
            end else begin : g_rest
                assign at_pos = !lt_reg[gi] && lt_reg[gi-1];
            end
            assign take_up = !lt_reg[gi];

            always_ff @(posedge aclk) begin
                if (cmd.commit && add_ok && take_up) begin
                    if (at_pos) begin
                        entry_reg[gi] <= value_reg;
                    end else begin
                        entry_reg[gi] <= entry_reg[(gi == 0) ? 0 : gi-1];
                    end
                end else if (cmd.commit && rem_ok && take_up && (gi < CAPACITY-1)) begin
                    entry_reg[gi] <= entry_reg[(gi < CAPACITY-1) ? gi+1 : gi];
                end
            end
        end
    endgenerate

    assign res_success = success_reg;
    assign res_full    = full_reg;
    assign res_count   = count_out_reg;

endmodule

`default_nettype wire

[rtl/sorted_set_table_unit.sv]
`default_nettype none
// Sorted set table: a bounded set of distinct signed 32-bit values held in
// ascending order in a shifting register table with one comparator per entry.
// Input channel (s_): one request per transfer. s_tuser carries the request
// kind (add, remove, query); s_tdata carries the value.
// Result channel (m_): exactly one result transfer per request, in order:
// success flag, full flag and element count after the request.
// Each accepted request runs a compare state (against every entry at once),
// then an update state (shift the table and load the result register).
// A new request is taken no earlier than the update of the one before it,
// as set by the compare-then-update sequence through the shared entry table.
// The result register parts the channels: a new request is taken while a
// result waits. When the receiver stalls, the finished update holds until the
// result register frees, and s_tready drops meanwhile.
// Reset (aresetn low, synchronous): the table becomes empty and no result is
// pending. Entry contents are not cleared; only entries below the count are
// ever looked at. Unused request kind 3 leaves the table unchanged and
// reports success 0.

module sorted_set_table_unit #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // [31:0] value (signed)
    input  wire logic [1:0]  s_tuser,  // [1:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata   // [0] success, [1] table_full, [8:2] element_count
);
    import ssetb_pkg::*;

    dp_cmd_t            cmd;
    logic               res_success;
    logic               res_full;
    logic [COUNT_W-1:0] res_count;

    // Sequence each request through compare and update
    ssetb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Hold the table, comparators and result register
    ssetb_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .req_mode    (s_tuser),
        .req_value   ($signed(s_tdata)),
        .res_success (res_success),
        .res_full    (res_full),
        .res_count   (res_count)
    );

    // Pack the result; pad to whole bytes
    assign m_tdata = {7'd0, res_count, res_full, res_success};

    // A transfer in is always followed by a compare cycle
    a_accept_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> cmd.compare)
        else $error("compare did not follow an accepted request");

    // A commit always presents a result on the next cycle
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("result missing after commit");

    // Never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.commit && m_tvalid && !m_tready))
        else $error("pending result overwritten");

    // Compare and commit are separate phases
    a_phases: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.compare && cmd.commit))
        else $error("compare and commit in the same cycle");

endmodule

`default_nettype wire
